>>> rtl/core/cdps_pkg.sv
`timescale 1ns / 1ps

package cdps_pkg;

  typedef struct packed {
    logic [15:0] sample_u;
    logic [15:0] sample_v;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef enum logic [2:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_CENTER_Z    = 3'd2,
    REG_DISK_RADIUS = 3'd3,
    REG_AXIS_U      = 3'd4,
    REG_AXIS_V      = 3'd5
  } cfg_reg_t;

  localparam int QBITS = 17;
  localparam int MAG_W = 17;
  localparam int REM_W = 18;
  localparam int XY_W  = 34;
  localparam int Z_W   = 33;

  localparam logic signed [XY_W-1:0] GAIN = 34'sd652032874;

  localparam int ATAN_ENTRIES = 30;
  localparam logic [29:0] ATAN_TAB [ATAN_ENTRIES] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
    30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
    30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
    30'd20, 30'd10, 30'd5, 30'd3, 30'd1
  };

endpackage

>>> rtl/core/cdps_div_cell.sv
`timescale 1ns / 1ps

module cdps_div_cell
  import cdps_pkg::*;
#(
  parameter int SIDE_W = 21
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid_in,
  input  logic [REM_W-1:0]  rem_in,
  input  logic [MAG_W-1:0]  div_in,
  input  logic [QBITS-1:0]  quo_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              valid_out,
  output logic [REM_W-1:0]  rem_out,
  output logic [MAG_W-1:0]  div_out,
  output logic [QBITS-1:0]  quo_out,
  output logic [SIDE_W-1:0] side_out
);

  logic             ge;
  logic [REM_W-1:0] diff;
  logic [REM_W-1:0] rem_keep;

  always_comb begin
    ge       = rem_in >= {1'b0, div_in};
    diff     = rem_in - {1'b0, div_in};
    rem_keep = ge ? diff : rem_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= {rem_keep[REM_W-2:0], 1'b0};
      div_out  <= div_in;
      quo_out  <= {quo_in[QBITS-2:0], ge};
      side_out <= side_in;
    end
  end

endmodule

>>> rtl/core/cdps_cordic_cell.sv
`timescale 1ns / 1ps

module cdps_cordic_cell
  import cdps_pkg::*;
#(
  parameter int STAGE  = 0,
  parameter int SIDE_W = 19
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   valid_in,
  input  logic signed [XY_W-1:0] x_in,
  input  logic signed [XY_W-1:0] y_in,
  input  logic signed [Z_W-1:0]  z_in,
  input  logic [SIDE_W-1:0]      side_in,
  output logic                   valid_out,
  output logic signed [XY_W-1:0] x_out,
  output logic signed [XY_W-1:0] y_out,
  output logic signed [Z_W-1:0]  z_out,
  output logic [SIDE_W-1:0]      side_out
);

  localparam logic signed [Z_W-1:0] ANG = $signed({{(Z_W-30){1'b0}}, ATAN_TAB[STAGE]});

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;

  always_comb begin
    dx = y_in >>> STAGE;
    dy = x_in >>> STAGE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[Z_W-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ANG;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ANG;
      end
      side_out <= side_in;
    end
  end

endmodule

>>> rtl/core/concentric_disk_point_sampling_core.sv
`timescale 1ns / 1ps

// Concentric disk point sampler. Each transfer on the input channel carries one
// unit-square sample, and exactly one transfer on the output channel returns the
// mapped 3D point in signed Q16.16, saturated per coordinate.
// The datapath is a row of cells: 17 divider cells form the wedge ratio one
// quotient bit each, then CORDIC_STAGES rotation cells, capped at the length of
// the arctangent table, turn the angle into cos and sin, followed by the radius
// and axis multipliers. One sample is taken every cycle while the output is not
// stalled. The configuration channel is always ready; registers are to be written
// only while no sample is in flight, which the block itself does not enforce.
// Reset clears the pipeline and loads the default center, radius and axes.
// When the receiver holds ready low, the whole pipeline and the input side
// stall until the waiting point is taken.

module concentric_disk_point_sampling_core
  import cdps_pkg::*;
#(
  parameter int CORDIC_STAGES = 18
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  sample_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output point_t      out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [62:0] cfg_data
);

  localparam int NSTG    = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
  localparam int DSIDE_W = MAG_W + 4;
  localparam int CSIDE_W = MAG_W + 2;

  logic signed [31:0] center [3];
  logic [31:0]        disk_radius;
  logic [62:0]        axis_u;
  logic [62:0]        axis_v;

  logic en;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      center[0]   <= '0;
      center[1]   <= '0;
      center[2]   <= '0;
      disk_radius <= 32'd65536;
      axis_u      <= 63'd524288;
      axis_v      <= 63'd1099511627776;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_X:    center[0]   <= $signed(cfg_data[31:0]);
        REG_CENTER_Y:    center[1]   <= $signed(cfg_data[31:0]);
        REG_CENTER_Z:    center[2]   <= $signed(cfg_data[31:0]);
        REG_DISK_RADIUS: disk_radius <= cfg_data[31:0];
        REG_AXIS_U:      axis_u      <= cfg_data;
        REG_AXIS_V:      axis_v      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Wedge selection.
  logic signed [18:0] a;
  logic signed [18:0] b;
  logic [MAG_W-1:0]   abs_a;
  logic [MAG_W-1:0]   abs_b;
  logic [MAG_W-1:0]   w_r;
  logic [MAG_W-1:0]   w_mn;
  logic [MAG_W-1:0]   w_md;
  logic               w_neg;
  logic               w_zero;
  logic [1:0]         w_sel;

  always_comb begin
    a      = $signed({2'b00, in_data.sample_u, 1'b0}) - 19'sd65536;
    b      = $signed({2'b00, in_data.sample_v, 1'b0}) - 19'sd65536;
    abs_a  = a[18] ? MAG_W'(-a) : MAG_W'(a);
    abs_b  = b[18] ? MAG_W'(-b) : MAG_W'(b);
    w_zero = 1'b0;
    if (a > -b) begin
      if (a > b) begin
        w_sel = 2'd0; w_r = abs_a; w_mn = abs_b; w_md = abs_a; w_neg = b[18];
      end else begin
        w_sel = 2'd1; w_r = abs_b; w_mn = abs_a; w_md = abs_b; w_neg = !a[18];
      end
    end else begin
      if (a < b) begin
        w_sel = 2'd2; w_r = abs_a; w_mn = abs_b; w_md = abs_a; w_neg = !b[18];
      end else begin
        w_sel = 2'd3; w_r = abs_b; w_mn = abs_a; w_md = abs_b; w_neg = a[18];
        w_zero = (b == 19'sd0);
      end
    end
  end

  logic               d_valid [QBITS+1];
  logic [REM_W-1:0]   d_rem   [QBITS+1];
  logic [MAG_W-1:0]   d_div   [QBITS+1];
  logic [QBITS-1:0]   d_quo   [QBITS+1];
  logic [DSIDE_W-1:0] d_side  [QBITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid[0] <= 1'b0;
    end else if (en) begin
      d_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_rem[0]  <= {1'b0, w_mn};
      d_div[0]  <= w_md;
      d_quo[0]  <= '0;
      d_side[0] <= {w_r, w_neg, w_zero, w_sel};
    end
  end

  for (genvar i = 0; i < QBITS; i++) begin : g_div
    cdps_div_cell #(.SIDE_W(DSIDE_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .valid_in (d_valid[i]),
      .rem_in   (d_rem[i]),
      .div_in   (d_div[i]),
      .quo_in   (d_quo[i]),
      .side_in  (d_side[i]),
      .valid_out(d_valid[i+1]),
      .rem_out  (d_rem[i+1]),
      .div_out  (d_div[i+1]),
      .quo_out  (d_quo[i+1]),
      .side_out (d_side[i+1])
    );
  end

  // Angle in units of pi/4, folded into one quarter turn.
  logic [DSIDE_W-1:0] t_side;
  logic signed [19:0] t_q;
  logic signed [19:0] t_ang;
  logic [20:0]        t_off;
  logic signed [17:0] t_fold;
  logic signed [Z_W-1:0] t_z;

  always_comb begin
    t_side = d_side[QBITS];
    t_q    = $signed({3'b000, d_quo[QBITS]});
    if (t_side[3]) begin
      t_q = -t_q;
    end
    t_ang = $signed({1'b0, t_side[1:0], 17'd0}) + t_q;
    if (t_side[2]) begin
      t_ang = '0;
    end
    t_off  = 21'($signed({t_ang[19], t_ang}) + 21'sd65536);
    t_fold = $signed({1'b0, t_off[16:0]}) - 18'sd65536;
    t_z    = $signed({{(Z_W-18){t_fold[17]}}, t_fold}) <<< 13;
  end

  logic                   c_valid [NSTG+1];
  logic signed [XY_W-1:0] c_x     [NSTG+1];
  logic signed [XY_W-1:0] c_y     [NSTG+1];
  logic signed [Z_W-1:0]  c_z     [NSTG+1];
  logic [CSIDE_W-1:0]     c_side  [NSTG+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid[0] <= 1'b0;
    end else if (en) begin
      c_valid[0] <= d_valid[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_x[0]    <= GAIN;
      c_y[0]    <= '0;
      c_z[0]    <= t_z;
      c_side[0] <= {t_side[DSIDE_W-1:4], t_off[18:17]};
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_cordic
    cdps_cordic_cell #(.STAGE(i), .SIDE_W(CSIDE_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .valid_in (c_valid[i]),
      .x_in     (c_x[i]),
      .y_in     (c_y[i]),
      .z_in     (c_z[i]),
      .side_in  (c_side[i]),
      .valid_out(c_valid[i+1]),
      .x_out    (c_x[i+1]),
      .y_out    (c_y[i+1]),
      .z_out    (c_z[i+1]),
      .side_out (c_side[i+1])
    );
  end

  // Undo the fold and scale the radius.
  logic signed [XY_W-1:0] f_c;
  logic signed [XY_W-1:0] f_s;
  logic [48:0]            f_prod;
  logic [48:0]            f_rnd;

  always_comb begin
    unique case (c_side[NSTG][1:0])
      2'd0: begin f_c = c_x[NSTG];  f_s = c_y[NSTG];  end
      2'd1: begin f_c = -c_y[NSTG]; f_s = c_x[NSTG];  end
      2'd2: begin f_c = -c_x[NSTG]; f_s = -c_y[NSTG]; end
      2'd3: begin f_c = c_y[NSTG];  f_s = -c_x[NSTG]; end
    endcase
    f_prod = 49'(c_side[NSTG][CSIDE_W-1:2]) * 49'(disk_radius);
    f_rnd  = f_prod + 49'd32768;
  end

  logic                   m1_valid;
  logic [32:0]            m1_s;
  logic signed [XY_W-1:0] m1_c;
  logic signed [XY_W-1:0] m1_sn;
  logic                   m2_valid;
  logic signed [67:0]     m2_pc;
  logic signed [67:0]     m2_ps;
  logic                   m3_valid;
  logic signed [37:0]     m3_pu;
  logic signed [37:0]     m3_pv;
  logic                   m4_valid;
  logic signed [58:0]     m4_tu [3];
  logic signed [58:0]     m4_tv [3];
  logic signed [67:0]     r_pc;
  logic signed [67:0]     r_ps;

  assign r_pc = m2_pc + 68'sd536870912;
  assign r_ps = m2_ps + 68'sd536870912;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid  <= 1'b0;
      m2_valid  <= 1'b0;
      m3_valid  <= 1'b0;
      m4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      m1_valid  <= c_valid[NSTG];
      m2_valid  <= m1_valid;
      m3_valid  <= m2_valid;
      m4_valid  <= m3_valid;
      out_valid <= m4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_s  <= f_rnd[48:16];
      m1_c  <= f_c;
      m1_sn <= f_s;
      m2_pc <= $signed({1'b0, m1_s}) * m1_c;
      m2_ps <= $signed({1'b0, m1_s}) * m1_sn;
      m3_pu <= r_pc[67:30];
      m3_pv <= r_ps[67:30];
    end
  end

  logic signed [41:0] o_sum [3];
  logic signed [31:0] o_sat [3];

  for (genvar j = 0; j < 3; j++) begin : g_coord
    logic signed [58:0] ru;
    logic signed [58:0] rv;

    always_ff @(posedge clk) begin
      if (en) begin
        m4_tu[j] <= m3_pu * $signed(axis_u[21*j +: 21]);
        m4_tv[j] <= m3_pv * $signed(axis_v[21*j +: 21]);
      end
    end

    always_comb begin
      ru       = m4_tu[j] + 59'sd262144;
      rv       = m4_tv[j] + 59'sd262144;
      o_sum[j] = 42'(center[j]) + 42'($signed(ru[58:19])) + 42'($signed(rv[58:19]));
      if (o_sum[j] > 42'sd2147483647) begin
        o_sat[j] = 32'h7FFF_FFFF;
      end else if (o_sum[j] < -42'sd2147483648) begin
        o_sat[j] = 32'h8000_0000;
      end else begin
        o_sat[j] = o_sum[j][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.point_x <= o_sat[0];
      out_data.point_y <= o_sat[1];
      out_data.point_z <= o_sat[2];
    end
  end

endmodule
